>>> design/fld_pkg.sv
`default_nettype none

package fld_pkg;

  // Fixed field widths of the sample and result beats and the threshold.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned PCT_W    = 8;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_HISTORY_DEPTH = 20;
  localparam int unsigned DEF_FRAME_MAX     = 4096;

  // Threshold register reset value and the percent scale of the deviation test.
  localparam logic [PCT_W-1:0] PCT_RESET = 8'd30;
  localparam int unsigned      PCT_SCALE = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       last_sample;
  } fld_in_t;

  typedef struct packed {
    logic             change_detected;
    logic [MAG_W-1:0] frame_magnitude;
    logic             history_full;
  } fld_out_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DIV_RE,
    ST_WAIT_RE,
    ST_DIV_IM,
    ST_WAIT_IM,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_ROOT,
    ST_SCALE,
    ST_DIFF,
    ST_PRODUCT,
    ST_DONE
  } fld_state_e;

endpackage

`default_nettype wire

>>> design/frame_level_change_detector_core.sv
// Frame level change detector.
//
// Sample beats (I, Q, last flag) enter on the in_* valid/ready channel and are
// summed at one beat per cycle. Beats beyond FRAME_MAX in a frame are dropped,
// but a dropped beat marked last still closes the frame. After the last beat
// the input channel is held off (in_ready_o low) while the frame result is
// computed: a shared bit-serial divider forms |mean I| and |mean Q| one bit per
// cycle, one 17x17 multiplier squares them, a bit-serial root unit produces the
// magnitude, and the scale, difference and product steps run the deviation
// test against the history sum. Most of the frame-end computation time is
// spent in the serial divider. One result beat leaves per frame on the out_*
// channel from an output register; sample beats of the next frame are still
// accepted while that beat waits, and only the next frame end waits for the
// receiver to take it. The threshold register is written on the cfg_* channel,
// which is always ready. Reset clears the accumulators, the history fill and
// sum, and sets the threshold to 30 percent; the history memory itself is not
// cleared, since slots fill in order and a slot not yet written is never used.

`default_nettype none

module frame_level_change_detector_core #(
  parameter int unsigned HISTORY_DEPTH = fld_pkg::DEF_HISTORY_DEPTH,
  parameter int unsigned FRAME_MAX     = fld_pkg::DEF_FRAME_MAX
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire fld_pkg::fld_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output fld_pkg::fld_out_t                 out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fld_pkg::PCT_W-1:0]    cfg_data_i
);

  localparam int unsigned SAMPLE_W = fld_pkg::SAMPLE_W;
  localparam int unsigned MAG_W    = fld_pkg::MAG_W;
  localparam int unsigned PCT_W    = fld_pkg::PCT_W;

  // Frame sample count and signed accumulator widths.
  localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);
  localparam int unsigned ACC_W = CNT_W + SAMPLE_W + 1;
  localparam int unsigned DVD_W = ACC_W - 1;
  // The magnitude of a mean component never exceeds 2^15.
  localparam int unsigned QUO_W = SAMPLE_W + 1;
  localparam int unsigned SQ_W  = 2 * QUO_W;
  localparam int unsigned RAD_W = 2 * MAG_W;
  // History bookkeeping.
  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = MAG_W + FILL_W;
  localparam int unsigned CMP_W  = SUM_W + PCT_W;

  fld_pkg::fld_state_e state_q, state_d;

  logic [PCT_W-1:0]  pct_q;
  logic [ACC_W-1:0]  acc_re_q;
  logic [ACC_W-1:0]  acc_im_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic              out_valid_q;
  fld_pkg::fld_out_t out_data_q;

  logic [QUO_W-1:0] mean_re_q;
  logic [QUO_W-1:0] mean_im_q;
  logic [SQ_W-1:0]  sq_q;
  logic [MAG_W-1:0] mag_q;
  logic [SUM_W-1:0] scaled_q;
  logic [SUM_W-1:0] diff_q;
  logic [CMP_W-1:0] lhs_q;
  logic [CMP_W-1:0] rhs_q;

  // Control strobes from the sequencer.
  logic in_fire;
  logic keep;
  logic div_start;
  logic root_start;
  logic finish;

  logic [ACC_W-1:0] ext_re;
  logic [ACC_W-1:0] ext_im;
  logic [ACC_W-1:0] abs_re;
  logic [ACC_W-1:0] abs_im;
  logic [DVD_W-1:0] dividend;
  logic             div_done;
  logic [DVD_W-1:0] quotient;

  logic [QUO_W-1:0] mul_op;
  logic [SQ_W-1:0]  mul_prod;
  logic [SQ_W-1:0]  sq_sum;
  logic             root_done;
  logic [MAG_W-1:0] root;

  logic             full;
  logic [MAG_W-1:0] ram_rdata;
  logic [MAG_W-1:0] old_mag;
  logic             change;
  logic [SLOT_W-1:0] slot_next;

  // ---------------------------------------------------------------------------
  // Sequencer. Samples are taken only while accumulating; every other state is
  // one step of the frame-end computation.
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == fld_pkg::ST_ACCUM);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    root_start = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      fld_pkg::ST_ACCUM: begin
        if (in_fire && in_data_i.last_sample) begin
          state_d = fld_pkg::ST_DIV_RE;
        end
      end
      fld_pkg::ST_DIV_RE: begin
        div_start = 1'b1;
        state_d   = fld_pkg::ST_WAIT_RE;
      end
      fld_pkg::ST_WAIT_RE: begin
        if (div_done) begin
          state_d = fld_pkg::ST_DIV_IM;
        end
      end
      fld_pkg::ST_DIV_IM: begin
        div_start = 1'b1;
        state_d   = fld_pkg::ST_WAIT_IM;
      end
      fld_pkg::ST_WAIT_IM: begin
        if (div_done) begin
          state_d = fld_pkg::ST_SQ_RE;
        end
      end
      fld_pkg::ST_SQ_RE: begin
        state_d = fld_pkg::ST_SQ_IM;
      end
      fld_pkg::ST_SQ_IM: begin
        root_start = 1'b1;
        state_d    = fld_pkg::ST_ROOT;
      end
      fld_pkg::ST_ROOT: begin
        if (root_done) begin
          state_d = fld_pkg::ST_SCALE;
        end
      end
      fld_pkg::ST_SCALE: begin
        state_d = fld_pkg::ST_DIFF;
      end
      fld_pkg::ST_DIFF: begin
        state_d = fld_pkg::ST_PRODUCT;
      end
      fld_pkg::ST_PRODUCT: begin
        state_d = fld_pkg::ST_DONE;
      end
      fld_pkg::ST_DONE: begin
        // The result leaves only once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          finish  = 1'b1;
          state_d = fld_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = fld_pkg::ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fld_pkg::ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= fld_pkg::PCT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pct_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame accumulation. The last beat is summed like any other before the
  // frame-end steps start; the sums are cleared when the result is released.
  // ---------------------------------------------------------------------------
  assign keep   = (cnt_q < CNT_W'(FRAME_MAX));
  assign ext_re = {{(ACC_W - SAMPLE_W){in_data_i.sample_i[SAMPLE_W-1]}}, in_data_i.sample_i};
  assign ext_im = {{(ACC_W - SAMPLE_W){in_data_i.sample_q[SAMPLE_W-1]}}, in_data_i.sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
      cnt_q    <= '0;
    end else if (finish) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
      cnt_q    <= '0;
    end else if (in_fire && keep) begin
      acc_re_q <= acc_re_q + ext_re;
      acc_im_q <= acc_im_q + ext_im;
      cnt_q    <= cnt_q + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Mean components. Only their magnitudes matter for the squared length, and
  // truncation toward zero of a signed mean equals the floor of |sum| / count.
  // ---------------------------------------------------------------------------
  assign abs_re   = acc_re_q[ACC_W-1] ? (ACC_W'(0) - acc_re_q) : acc_re_q;
  assign abs_im   = acc_im_q[ACC_W-1] ? (ACC_W'(0) - acc_im_q) : acc_im_q;
  assign dividend = (state_q == fld_pkg::ST_DIV_RE) ? abs_re[DVD_W-1:0] : abs_im[DVD_W-1:0];

  fld_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (div_done && (state_q == fld_pkg::ST_WAIT_RE)) begin
      mean_re_q <= quotient[QUO_W-1:0];
    end
    if (div_done && (state_q == fld_pkg::ST_WAIT_IM)) begin
      mean_im_q <= quotient[QUO_W-1:0];
    end
  end

  // One multiplier squares both components on consecutive cycles; the sum of
  // squares goes straight into the root unit.
  assign mul_op   = (state_q == fld_pkg::ST_SQ_RE) ? mean_re_q : mean_im_q;
  assign mul_prod = SQ_W'(mul_op) * SQ_W'(mul_op);
  assign sq_sum   = sq_q + mul_prod;

  always_ff @(posedge clk_i) begin
    if (state_q == fld_pkg::ST_SQ_RE) begin
      sq_q <= mul_prod;
    end
  end

  fld_isqrt #(
    .ROOT_W (MAG_W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sq_sum[RAD_W-1:0]),
    .done_o     (root_done),
    .root_o     (root)
  );

  // ---------------------------------------------------------------------------
  // Deviation test: 100 * |DEPTH * m - S| >= pct * S, in scale, difference and product steps.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (root_done && (state_q == fld_pkg::ST_ROOT)) begin
      mag_q <= root;
    end
    if (state_q == fld_pkg::ST_SCALE) begin
      scaled_q <= SUM_W'(mag_q) * SUM_W'(HISTORY_DEPTH);
    end
    if (state_q == fld_pkg::ST_DIFF) begin
      diff_q <= (scaled_q >= sum_q) ? (scaled_q - sum_q) : (sum_q - scaled_q);
    end
    if (state_q == fld_pkg::ST_PRODUCT) begin
      lhs_q <= CMP_W'(diff_q) * CMP_W'(fld_pkg::PCT_SCALE);
      rhs_q <= CMP_W'(sum_q) * CMP_W'(pct_q);
    end
  end

  // ---------------------------------------------------------------------------
  // History. Slots fill in order from zero, so before the history is full the
  // slot about to be written has never been written and counts as zero.
  // ---------------------------------------------------------------------------
  assign full      = (fill_q == FILL_W'(HISTORY_DEPTH));
  assign old_mag   = full ? ram_rdata : '0;
  assign change    = full && !((sum_q == '0) && (mag_q == '0)) && (lhs_q >= rhs_q);
  assign slot_next = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : (slot_q + SLOT_W'(1));

  fld_ram #(
    .WIDTH (MAG_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (finish),
    .waddr_i (slot_q),
    .wdata_i (mag_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (finish) begin
      slot_q <= slot_next;
      sum_q  <= sum_q - SUM_W'(old_mag) + SUM_W'(mag_q);
      if (!full) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. A waiting beat never blocks sample accumulation.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q.change_detected <= change;
      out_data_q.frame_magnitude <= mag_q;
      out_data_q.history_full    <= full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_change_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.change_detected) |-> out_data_o.history_full)
    else $error("change flagged before the history was full");

  a_slot_follows_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (slot_q == SLOT_W'(fill_q)))
    else $error("write slot does not match fill level while filling");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == fld_pkg::ST_WAIT_RE) || (state_q == fld_pkg::ST_WAIT_IM)))
    else $error("divider finished outside a wait state");

  a_root_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == fld_pkg::ST_ROOT))
    else $error("root unit finished outside its wait state");

endmodule

`default_nettype wire

>>> design/fld_ram.sv
`default_nettype none

module fld_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/fld_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module fld_div #(
  parameter int unsigned DVD_W = 29,
  parameter int unsigned DVS_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  shr_q, shr_d;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic           fits;

  always_comb begin
    rem_sh  = {rem_q, shr_q[DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    shr_d   = {shr_q[DVD_W-2:0], fits};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DVD_W);
    end else if (busy_q) begin
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      shr_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shr_q <= shr_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shr_q;

endmodule

`default_nettype wire

>>> design/fld_isqrt.sv
`default_nettype none

// Floor integer square root, two radicand bits and one root bit per cycle.
module fld_isqrt #(
  parameter int unsigned ROOT_W = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*ROOT_W-1:0] radicand_i,
  output logic                     done_o,
  output logic      [ROOT_W-1:0]   root_o
);

  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned STEP_W = $clog2(ROOT_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [RAD_W-1:0]  rad_q, rad_d;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    fits    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
    rem_d   = fits ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_d  = {root_q[ROOT_W-2:0], fits};
    rad_d   = {rad_q[RAD_W-3:0], 2'b00};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(ROOT_W);
    end else if (busy_q) begin
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= radicand_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire
